### hw/rtl/cluster_chain_extent_map_macros.svh
// Assertion macros for the cluster chain extent map
`ifndef CLUSTER_CHAIN_EXTENT_MAP_MACROS_SVH
`define CLUSTER_CHAIN_EXTENT_MAP_MACROS_SVH

// Implication checked on every clock edge outside reset
`define CCEM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the following cycle
`define CCEM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/ccem_pkg.sv
// ---------------------------------------------------------------------------
// ccem_pkg
// Shared types and constants of the cluster chain extent map.
// ---------------------------------------------------------------------------
package ccem_pkg;

    localparam logic [31:0] BAD_VALUE = 32'h0FFF_FFF7;
    localparam logic [31:0] EOC_VALUE = 32'h0FFF_FFF8;
    localparam logic [23:0] OFFSET_LIMIT = 24'h80_0000;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_FAT    = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_BAD    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_NEED     = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_BROKEN   = 3'd2,
        ST_SHORT    = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_LOOK_OK  = 3'd5,
        ST_LOOK_ERR = 3'd6
    } status_t;

    // classification done by the front end
    typedef enum logic [2:0] {
        CMD_START,
        CMD_EOC,
        CMD_BROKEN,
        CMD_LINK,
        CMD_LOOKUP,
        CMD_REJECT
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WALK = 2'd1,
        PH_DONE = 2'd2,
        PH_FAIL = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SRCH,
        BK_WAIT,
        BK_FETCH,
        BK_FWAIT,
        BK_MUL,
        BK_OUT
    } bk_state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] value;
        logic [22:0] offset;
    } qitem_t;

    localparam int unsigned QITEM_W = $bits(qitem_t);

endpackage

### hw/rtl/cluster_chain_extent_map.sv
// ---------------------------------------------------------------------------
// cluster_chain_extent_map
// FAT32 cluster chain walker building an extent table, with lookups.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one item per request, req_type selects
//   start of chain, FAT value or lookup. An item is taken when in_valid is
//   high and in_stall low; a two-entry queue sits behind the front end.
// Output channel (out_valid/out_stall): exactly one result item per input
//   item, in order. The result holds in its register while out_stall is high
//   and the queue keeps accepting until full.
// Sequence: start, link and broken entries go straight to the output
//   register; end of chain passes BK_MUL, BK_WAIT (registered multiply
//   for the size check); a lookup repeats BK_SRCH, BK_FWAIT per binary
//   search step over the extent RAM, then BK_FETCH. The back end works on
//   one item at a time, bounded by the single RAM read port of the search.
// Configuration (APB): start cluster at 0x0, file size at 0x4,
//   cluster size in bytes at 0x8; write only while idle.
// Reset: phase idle, empty table, registers to their defaults. The extent
//   RAM is not cleared; only entries already written are ever read.
// ---------------------------------------------------------------------------
`include "cluster_chain_extent_map_macros.svh"

module cluster_chain_extent_map
    import ccem_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] fat_value,
    input  logic [22:0] lookup_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [27:0] next_fat_index,
    output logic [27:0] disk_cluster,
    output logic [23:0] chain_length
);

    // register addresses
    localparam logic [1:0] RA_FIRST = 2'd0;
    localparam logic [1:0] RA_SIZE  = 2'd1;
    localparam logic [1:0] RA_BPC   = 2'd2;

    logic [27:0] start_cl_reg;
    logic [31:0] file_size_reg;
    logic [19:0] bpc_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_cl_reg  <= 28'd2;
            file_size_reg <= 32'd0;
            bpc_reg       <= 20'd4096;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                RA_FIRST: start_cl_reg  <= pwdata[27:0];
                RA_SIZE:  file_size_reg <= pwdata;
                RA_BPC:   bpc_reg       <= pwdata[19:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            RA_FIRST: prdata = {4'd0, start_cl_reg};
            RA_SIZE:  prdata = file_size_reg;
            RA_BPC:   prdata = {12'd0, bpc_reg};
            default:  prdata = 32'd0;
        endcase
    end

    logic   q_push, q_full, q_pop, q_nonempty;
    qitem_t q_wdata, q_rdata;

    ccem_front u_front (
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .fat_value(fat_value),
        .lookup_offset(lookup_offset),
        .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
    );

    ccem_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .wdata(q_wdata), .full(q_full),
        .pop(q_pop), .nonempty(q_nonempty), .rdata(q_rdata)
    );

    ccem_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_nonempty(q_nonempty), .q_data(q_rdata), .q_pop(q_pop),
        .start_cluster(start_cl_reg), .file_size(file_size_reg),
        .cluster_bytes(bpc_reg),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .next_fat_index(next_fat_index),
        .disk_cluster(disk_cluster), .chain_length(chain_length)
    );

    // a stalled result must hold
    `CCEM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(status) && $stable(disk_cluster))
    // only a successful lookup carries a disk cluster
    `CCEM_ASSERT_IMPL(a_disk_zero, out_valid && status != ST_LOOK_OK,
        disk_cluster == 28'd0)
    // next index only with status need-next
    `CCEM_ASSERT_IMPL(a_next_zero, out_valid && status != ST_NEED,
        next_fat_index == 28'd0)

endmodule

### hw/rtl/ccem_ram.sv
// ---------------------------------------------------------------------------
// ccem_ram
// Generic single-port-write, one-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module ccem_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/ccem_front.sv
// ---------------------------------------------------------------------------
// ccem_front
// Accepts items, classifies the request and FAT value, feeds the queue.
// ---------------------------------------------------------------------------
module ccem_front
    import ccem_pkg::*;
(
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] fat_value,
    input  logic [22:0] lookup_offset,
    output logic        q_push,
    output qitem_t      q_data,
    input  logic        q_full
);

    qitem_t item;

    always_comb
    begin
        item.value  = fat_value;
        item.offset = lookup_offset;
        case (req_t'(req_type))
            REQ_START:  item.cmd = CMD_START;
            REQ_LOOKUP: item.cmd = CMD_LOOKUP;
            REQ_FAT:
            begin
                if (fat_value >= EOC_VALUE)
                    item.cmd = CMD_EOC;
                else if (fat_value == 32'd0 || fat_value == 32'd1 ||
                         fat_value == BAD_VALUE)
                    item.cmd = CMD_BROKEN;
                else
                    item.cmd = CMD_LINK;
            end
            default:    item.cmd = CMD_REJECT;
        endcase
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_data   = item;

endmodule

### hw/rtl/ccem_fifo.sv
// ---------------------------------------------------------------------------
// ccem_fifo
// Two-entry queue between front end and back end.
// ---------------------------------------------------------------------------
module ccem_fifo
    import ccem_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qitem_t wdata,
    output logic   full,
    input  logic   pop,
    output logic   nonempty,
    output qitem_t rdata
);

    qitem_t     slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign nonempty = cnt_reg != 2'd0;
    assign rdata    = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### hw/rtl/ccem_back.sv
// ---------------------------------------------------------------------------
// ccem_back
// Chain walker, extent table and binary search; one item at a time.
// ---------------------------------------------------------------------------
module ccem_back
    import ccem_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_nonempty,
    input  qitem_t      q_data,
    output logic        q_pop,
    input  logic [27:0] start_cluster,
    input  logic [31:0] file_size,
    input  logic [19:0] cluster_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [27:0] next_fat_index,
    output logic [27:0] disk_cluster,
    output logic [23:0] chain_length
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C    = CW'(1);
    localparam logic [CW:0]   ONE_W    = (CW+1)'(1);

    bk_state_t   state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [CW-1:0] ext_cnt_reg, ext_cnt_next;
    logic [27:0] walk_cl_reg, walk_cl_next;
    logic [23:0] walk_cnt_reg, walk_cnt_next;
    logic [22:0] open_start_reg, open_start_next;
    logic [27:0] open_base_reg, open_base_next;
    logic [CW:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0] found_reg, found_next;
    logic [22:0] off_reg, off_next;
    logic [51:0] cover_reg, cover_next;
    logic [2:0]  st_reg, st_next;
    logic [27:0] nxt_reg, nxt_next;
    logic [27:0] disk_reg, disk_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [22:0]   start_rd;
    logic [27:0]   base_rd;
    logic [CW:0]   mid;

    ccem_ram #(.WIDTH(23), .DEPTH(TABLE_DEPTH)) u_start_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(open_start_reg),
        .raddr(raddr), .rdata(start_rd)
    );

    ccem_ram #(.WIDTH(28), .DEPTH(TABLE_DEPTH)) u_base_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(open_base_reg),
        .raddr(raddr), .rdata(base_rd)
    );

    assign waddr = ext_cnt_reg[AW-1:0];
    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign out_valid      = state_reg == BK_OUT;
    assign status         = st_reg;
    assign next_fat_index = nxt_reg;
    assign disk_cluster   = disk_reg;
    assign chain_length   = walk_cnt_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        ext_cnt_next    = ext_cnt_reg;
        walk_cl_next    = walk_cl_reg;
        walk_cnt_next   = walk_cnt_reg;
        open_start_next = open_start_reg;
        open_base_next  = open_base_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        found_next      = found_reg;
        off_next        = off_reg;
        cover_next      = cover_reg;
        st_next         = st_reg;
        nxt_next        = 28'd0;
        disk_next       = 28'd0;
        q_pop           = 1'b0;
        we              = 1'b0;
        raddr           = mid[AW-1:0];
        if (state_reg != BK_IDLE && state_reg != BK_OUT)
            nxt_next = nxt_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_nonempty)
                begin
                    q_pop = 1'b1;
                    state_next = BK_OUT;
                    case (q_data.cmd)
                        CMD_START:
                        begin
                            ext_cnt_next    = '0;
                            walk_cl_next    = start_cluster;
                            walk_cnt_next   = 24'd1;
                            open_start_next = 23'd0;
                            open_base_next  = start_cluster;
                            phase_next      = PH_WALK;
                            st_next         = ST_NEED;
                            nxt_next        = start_cluster;
                        end
                        CMD_EOC:
                        begin
                            if (phase_reg != PH_WALK)
                                st_next = (phase_reg == PH_DONE) ? ST_COMPLETE
                                                                 : ST_BROKEN;
                            else
                                state_next = BK_MUL;
                        end
                        CMD_BROKEN:
                        begin
                            if (phase_reg != PH_WALK)
                                st_next = (phase_reg == PH_DONE) ? ST_COMPLETE
                                                                 : ST_BROKEN;
                            else
                            begin
                                phase_next = PH_FAIL;
                                st_next    = ST_BROKEN;
                            end
                        end
                        CMD_LINK:
                        begin
                            if (phase_reg != PH_WALK)
                                st_next = (phase_reg == PH_DONE) ? ST_COMPLETE
                                                                 : ST_BROKEN;
                            else if (walk_cnt_reg >= OFFSET_LIMIT)
                            begin
                                phase_next = PH_FAIL;
                                st_next    = ST_OVERFLOW;
                            end
                            else if (q_data.value != {4'd0, walk_cl_reg} + 32'd1 &&
                                     ext_cnt_reg >= FULL_CNT)
                            begin
                                phase_next = PH_FAIL;
                                st_next    = ST_OVERFLOW;
                            end
                            else
                            begin
                                if (q_data.value != {4'd0, walk_cl_reg} + 32'd1)
                                begin
                                    we              = 1'b1;
                                    ext_cnt_next    = ext_cnt_reg + ONE_C;
                                    open_start_next = walk_cnt_reg[22:0];
                                    open_base_next  = q_data.value[27:0];
                                end
                                walk_cl_next  = q_data.value[27:0];
                                walk_cnt_next = walk_cnt_reg + 24'd1;
                                st_next       = ST_NEED;
                                nxt_next      = q_data.value[27:0];
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (phase_reg != PH_DONE || ext_cnt_reg == '0 ||
                                {1'b0, q_data.offset} >= walk_cnt_reg)
                                st_next = ST_LOOK_ERR;
                            else
                            begin
                                off_next   = q_data.offset;
                                lo_next    = '0;
                                hi_next    = {1'b0, ext_cnt_reg} - ONE_W;
                                found_next = '0;
                                state_next = BK_SRCH;
                            end
                        end
                        default: st_next = ST_LOOK_ERR;
                    endcase
                end
            end
            BK_MUL:
            begin
                cover_next = 52'(walk_cnt_reg) * 52'(cluster_bytes);
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                state_next = BK_OUT;
                if (cover_reg < 52'(file_size))
                begin
                    phase_next = PH_FAIL;
                    st_next    = ST_SHORT;
                end
                else if (ext_cnt_reg >= FULL_CNT)
                begin
                    phase_next = PH_FAIL;
                    st_next    = ST_OVERFLOW;
                end
                else
                begin
                    we           = 1'b1;
                    ext_cnt_next = ext_cnt_reg + ONE_C;
                    phase_next   = PH_DONE;
                    st_next      = ST_COMPLETE;
                end
            end
            BK_SRCH:
            begin
                if (lo_reg > hi_reg || hi_reg[CW])
                begin
                    raddr      = found_reg;
                    state_next = BK_FETCH;
                end
                else
                    state_next = BK_FWAIT;
            end
            BK_FWAIT:
            begin
                // start_rd holds entry mid
                if (start_rd <= off_reg)
                begin
                    found_next = mid[AW-1:0];
                    lo_next    = mid + ONE_W;
                end
                else if (mid == '0)
                    hi_next = {1'b1, {CW{1'b0}}};
                else
                    hi_next = mid - ONE_W;
                state_next = BK_SRCH;
            end
            BK_FETCH:
            begin
                raddr      = found_reg;
                state_next = BK_OUT;
                st_next    = ST_LOOK_OK;
                disk_next  = base_rd + 28'(off_reg - start_rd);
            end
            BK_OUT:
            begin
                nxt_next  = nxt_reg;
                disk_next = disk_reg;
                if (!out_stall)
                    state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            phase_reg      <= PH_IDLE;
            ext_cnt_reg    <= '0;
            walk_cl_reg    <= 28'd0;
            walk_cnt_reg   <= 24'd0;
            open_start_reg <= 23'd0;
            open_base_reg  <= 28'd0;
            st_reg         <= ST_NEED;
            nxt_reg        <= 28'd0;
            disk_reg       <= 28'd0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            ext_cnt_reg    <= ext_cnt_next;
            walk_cl_reg    <= walk_cl_next;
            walk_cnt_reg   <= walk_cnt_next;
            open_start_reg <= open_start_next;
            open_base_reg  <= open_base_next;
            st_reg         <= st_next;
            nxt_reg        <= nxt_next;
            disk_reg       <= disk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        found_reg <= found_next;
        off_reg   <= off_next;
        cover_reg <= cover_next;
    end

endmodule
